@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: when cause holds, effect is checked on the next edge.
`define ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ hdl/lrf_pkg.sv @@
// ----------------------------------------------------------------------------
// lrf_pkg
// Types and constants for the random-fade LED pixel update core.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam logic [7:0] PHASE_LAST = 8'd199;  // counter wraps after this
  localparam logic [7:0] PHASE_HALF = 8'd100;  // first phase of red reseeds

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // One store entry per LED.
  typedef struct packed {
    logic [2:0] wait_cnt;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // Random values and phase half that drive a reseed.
  typedef struct packed {
    logic       red_half;
    logic [7:0] level_a;
    logic [7:0] level_b;
    logic [2:0] wait_cnt;
  } seed_t;

endpackage

@@ hdl/lrf_pixel_calc.sv @@
// ----------------------------------------------------------------------------
// lrf_pixel_calc
// Next state of one LED entry: fade, dark wait countdown or reseed.
// ----------------------------------------------------------------------------
module lrf_pixel_calc (
  input  lrf_pkg::pix_t  cur,
  input  lrf_pkg::seed_t seed,
  input  logic [7:0]     fade_step,
  output lrf_pkg::pix_t  nxt
);
  import lrf_pkg::*;

  function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? 8'(a - b) : 8'd0;
  endfunction

  logic lit;

  assign lit = (cur.red != 8'd0) || (cur.green != 8'd0) || (cur.blue != 8'd0);

  always_comb begin
    nxt = cur;
    if (lit) begin
      nxt.red   = sat_sub(cur.red, fade_step);
      nxt.green = sat_sub(cur.green, fade_step);
      nxt.blue  = sat_sub(cur.blue, fade_step);
    end else if (cur.wait_cnt != 3'd0) begin
      nxt.wait_cnt = 3'(cur.wait_cnt - 3'd1);
    end else begin
      // reseed: green+blue in the first half of the frame, red+blue after
      nxt.red      = seed.red_half ? seed.level_a : 8'd0;
      nxt.green    = seed.red_half ? 8'd0 : seed.level_a;
      nxt.blue     = seed.level_b;
      nxt.wait_cnt = seed.wait_cnt;
    end
  end

endmodule

@@ hdl/led_random_fade_pixel_update_core.sv @@
// ----------------------------------------------------------------------------
// led_random_fade_pixel_update_core
// Per-LED random fade engine with a 200-phase frame counter.
// ----------------------------------------------------------------------------
// Each input item is either a pixel update (tuser = 0) or a frame tick
// (tuser = 1). A pixel update reads the LED's colour and wait count from an
// on-chip store, fades it, counts its dark wait down or reseeds it from the
// random fields, writes it back and returns the new colour. A frame tick only
// advances the phase counter (0..199) and returns it with index and colour 0.
// An index at or above LED_COUNT changes nothing and returns black.
// Items are taken one at a time: accept and store read, then, once the output
// register is free, modify, write back and load the output register.
// A finished result sits in the output register while the next item is taken.
// The store comes up all dark with no clearing pass: a per-LED valid bit,
// cleared by reset, makes an unwritten entry read as zero.
// fade_step may be written at any time the core is idle; reset value is 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_random_fade_pixel_update_core #(
  parameter int LED_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // fade step register
  input  logic        fade_step_wr_en,
  input  logic [7:0]  fade_step_wr_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_index[7:0], rand_level_a[15:8],
                                 // rand_level_b[23:16], rand_wait[26:24], zero pad
  input  logic        s_tuser,   // func: 0 pixel update, 1 frame tick
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // out_index[7:0], red[15:8], green[23:16],
                                 // blue[31:24], phase[39:32]
);
  import lrf_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

  // LED store and its valid bits
  pix_t                 mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_bits;
  pix_t                 rd_data;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_en;

  // item held while it is worked on
  logic       op_func;
  logic [7:0] op_idx;
  logic [7:0] op_level_a;
  logic [7:0] op_level_b;
  logic [2:0] op_wait;
  logic       op_inrange;

  logic [7:0] fade_step;
  logic [7:0] phase;
  logic [7:0] phase_next;

  state_t st, st_next;
  logic   accept;
  logic   finish;

  pix_t  cur_pix;
  pix_t  new_pix;
  seed_t seed;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    s_tready = 1'b0;
    finish   = 1'b0;
    case (st)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          st_next = ST_CALC;
        end
      end
      ST_CALC: begin
        // result goes out only when the output register is free
        if (!m_tvalid || m_tready) begin
          finish  = 1'b1;
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func    <= s_tuser;
      op_idx     <= s_tdata[7:0];
      op_level_a <= s_tdata[15:8];
      op_level_b <= s_tdata[23:16];
      op_wait    <= s_tdata[26:24];
      op_inrange <= {1'b0, s_tdata[7:0]} < LED_LIMIT;
    end
  end

  // ---------------- store ----------------
  assign rd_addr = s_tdata[IDX_W-1:0];
  assign wr_addr = op_idx[IDX_W-1:0];
  assign wr_en   = finish && (op_func == FUNC_PIXEL) && op_inrange;

  // one read port, one write port; read issued on accept, write back at finish
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= new_pix;
    end
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (accept) begin
        rd_valid <= valid_bits[rd_addr];
      end
      if (wr_en) begin
        valid_bits[wr_addr] <= 1'b1;
      end
    end
  end

  // never-written LEDs read as dark with no wait
  assign cur_pix = rd_valid ? rd_data : '0;

  assign seed.red_half = (phase >= PHASE_HALF);
  assign seed.level_a  = op_level_a;
  assign seed.level_b  = op_level_b;
  assign seed.wait_cnt = op_wait;

  lrf_pixel_calc u_calc (
    .cur       (cur_pix),
    .seed      (seed),
    .fade_step (fade_step),
    .nxt       (new_pix)
  );

  // ---------------- frame counter and register ----------------
  assign phase_next = (phase >= PHASE_LAST) ? 8'd0 : 8'(phase + 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 8'd0;
      fade_step <= 8'd1;
    end else begin
      if (finish && (op_func == FUNC_TICK)) begin
        phase <= phase_next;
      end
      if (fade_step_wr_en) begin
        fade_step <= fade_step_wr_data;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (op_func == FUNC_TICK) begin
        m_tdata <= {phase_next, 24'd0, 8'd0};
      end else if (!op_inrange) begin
        m_tdata <= {phase, 24'd0, op_idx};
      end else begin
        m_tdata <= {phase, new_pix.blue, new_pix.green, new_pix.red, op_idx};
      end
    end
  end

  // ---------------- checks ----------------
  `ASSERT_CLK(a_phase_range, phase <= PHASE_LAST, "phase counter out of range")
  `ASSERT_NEXT(a_accept_calc, accept, (st == ST_CALC) && !s_tready, "item not held for calc")
  `ASSERT_NEXT(a_finish_out, finish, m_tvalid, "finished item not presented")

endmodule
